@@ src/lcws_pkg.sv @@
// Package for the LED color wipe sequencer: widths, register indexes,
// mode flag positions, controller states and the controller/datapath structs.
// No dependencies.
`default_nettype none

package lcws_pkg;

  localparam int unsigned MaxLinesDef   = 64;
  localparam int unsigned MaxPatternDef = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CountW   = 7;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned NumW     = 8;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned LoopW    = 16;
  localparam int unsigned FreqW    = 8;
  localparam int unsigned FlagW    = 12;
  localparam int unsigned PatW     = 5;
  localparam int unsigned OffW     = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_COUNT  = 3'd0,
    REG_SEG_COUNT   = 3'd1,
    REG_LINE_LEN    = 3'd2,
    REG_SEG_LEN     = 3'd3,
    REG_MODE_FLAGS  = 3'd4,
    REG_LOOP_FREQ   = 3'd5,
    REG_BG_FREQ     = 3'd6,
    REG_PATTERN_LEN = 3'd7
  } lcws_reg_e;

  // Mode flag bit positions.
  localparam int unsigned FlagSimult     = 0;
  localparam int unsigned FlagAlternate  = 1;
  localparam int unsigned FlagForward    = 2;
  localparam int unsigned FlagSegForward = 3;
  localparam int unsigned FlagSegMode    = 4;
  localparam int unsigned FlagLooped     = 5;
  localparam int unsigned FlagBgLoop     = 6;
  localparam int unsigned FlagShiftPat   = 7;
  localparam int unsigned FlagAltWipe    = 8;
  localparam int unsigned FlagBgAlt      = 9;
  localparam int unsigned FlagAltSegDir  = 10;
  localparam int unsigned FlagAltSegMode = 11;

  // Register reset values.
  localparam logic [CountW-1:0] RstLineCount = 7'd64;
  localparam logic [CountW-1:0] RstSegCount  = 7'd8;
  localparam logic [CountW-1:0] RstLineLen   = 7'd0;
  localparam logic [CountW-1:0] RstSegLen    = 7'd0;
  localparam logic [FlagW-1:0]  RstFlags     = 12'd12;
  localparam logic [FreqW-1:0]  RstLoopFreq  = 8'd1;
  localparam logic [FreqW-1:0]  RstBgFreq    = 8'd2;
  localparam logic [PatW-1:0]   RstPatLen    = 5'd1;

  typedef enum logic [2:0] {
    ST_RST,
    ST_LOAD,
    ST_DIV,
    ST_IDLE,
    ST_START,
    ST_EMIT,
    ST_END
  } lcws_state_e;

  typedef struct packed {
    logic restart;
    logic div_load;
    logic div_step;
    logic start;
    logic emit;
    logic end_tick;
  } lcws_cmd_t;

  typedef struct packed {
    logic div_done;
    logic all_done;
    logic out_free;
    logic last;
    logic reload;
  } lcws_status_t;

endpackage

`default_nettype wire

@@ src/lcws_if.sv @@
// Handshake channel interfaces for the tick input and the result output.
// Depends on lcws_pkg.
`default_nettype none

interface lcws_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface lcws_res_if;
  import lcws_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] target_index;
  logic            target_is_segment;
  logic [IdxW-1:0] wipe_number;
  logic [IdxW-1:0] wipe_step;
  logic [OffW-1:0] pattern_offset;
  logic            background;
  logic            sequence_finished;
  logic            last;

  modport source (output valid, output target_index, output target_is_segment,
                  output wipe_number, output wipe_step, output pattern_offset,
                  output background, output sequence_finished, output last,
                  input ready);
  modport sink (input valid, input target_index, input target_is_segment,
                input wipe_number, input wipe_step, input pattern_offset,
                input background, input sequence_finished, input last,
                output ready);
endinterface

`default_nettype wire

@@ src/led_color_wipe_sequencer.sv @@
// Top level of the LED color wipe sequencer.
// Depends on lcws_pkg, lcws_if, lcws_ctrl and lcws_dp.
`default_nettype none

// Each accepted tick word with tick set produces one result word in
// sequential mode or one per visible wipe in simultaneous mode, one result
// per cycle while the output is taken, after a setup state and before an
// end update state. A tick word with tick clear, or one arriving after a
// finished, non-looping sequence, is taken and yields nothing. After reset,
// after every register write and after a loop that toggles segment mode,
// the wipe count is recomputed by repeated subtraction, one wipe per
// cycle, during which no tick is taken. Reset and a register write pass
// through ST_RST and ST_LOAD before the division, such a loop through
// ST_LOAD only.
// A result word waits in an output register, so the block keeps working
// on the rest of a tick while the sink stalls only as far as that one word.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i and
// restart the sequence; write them only while the block is idle.
module led_color_wipe_sequencer #(
  parameter int unsigned MAX_LINES   = lcws_pkg::MaxLinesDef,
  parameter int unsigned MAX_PATTERN = lcws_pkg::MaxPatternDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lcws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lcws_pkg::CfgDataW-1:0] cfg_data_i,
  lcws_tick_if.sink                          in_i,
  lcws_res_if.source                         out_o
);
  import lcws_pkg::*;

  // Commands from the controller and status back from the datapath.
  lcws_cmd_t    cmd;
  lcws_status_t st;

  lcws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .in_i     (in_i),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  lcws_dp #(
    .MAX_LINES   (MAX_LINES),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ src/lcws_ctrl.sv @@
// Controller state machine of the wipe sequencer: sequences restart, wipe
// count division, per-tick emission and end-of-tick update.
// Depends on lcws_pkg and lcws_if.
`default_nettype none

module lcws_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  lcws_tick_if.sink                 in_i,
  input  wire lcws_pkg::lcws_status_t st_i,
  output lcws_pkg::lcws_cmd_t       cmd_o
);
  import lcws_pkg::*;

  lcws_state_e state_q, state_d;
  logic        accept;

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RST:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (st_i.div_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept && in_i.tick && !st_i.all_done) state_d = ST_START;
      end
      ST_START: state_d = ST_EMIT;
      ST_EMIT:  if (st_i.out_free && st_i.last) state_d = ST_END;
      ST_END:   state_d = st_i.reload ? ST_LOAD : ST_IDLE;
      default:  state_d = ST_RST;
    endcase
    if (cfg_we_i) state_d = ST_RST;
  end

  always_comb begin
    cmd_o          = '0;
    in_i.ready     = 1'b0;
    case (state_q)
      ST_RST:   cmd_o.restart  = 1'b1;
      ST_LOAD:  cmd_o.div_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_IDLE:  in_i.ready     = 1'b1;
      ST_START: cmd_o.start    = 1'b1;
      ST_EMIT:  cmd_o.emit     = st_i.out_free;
      ST_END:   cmd_o.end_tick = 1'b1;
      default:  cmd_o          = '0;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> st_i.out_free) else $error("emit while output busy");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && st_i.last && !cfg_we_i) |=> (state_q == ST_END))
    else $error("last result not followed by end update");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && st_i.div_done && !cfg_we_i) |=> (state_q == ST_IDLE))
    else $error("division done but not idle");

endmodule

`default_nettype wire

@@ src/lcws_dp.sv @@
// Datapath of the wipe sequencer: configuration registers, sequence state,
// iterative wipe count divider, element evaluation and the output register.
// Depends on lcws_pkg and lcws_if.
`default_nettype none

module lcws_dp #(
  parameter int unsigned MAX_LINES   = lcws_pkg::MaxLinesDef,
  parameter int unsigned MAX_PATTERN = lcws_pkg::MaxPatternDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lcws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lcws_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire lcws_pkg::lcws_cmd_t         cmd_i,
  output lcws_pkg::lcws_status_t           st_o,
  lcws_res_if.source                       out_o
);
  import lcws_pkg::*;

  // Configuration registers.
  logic [CountW-1:0] line_cnt_q, seg_cnt_q, line_len_q, seg_len_q;
  logic [FlagW-1:0]  flags_q;
  logic [FreqW-1:0]  loop_freq_q, bg_freq_q;
  logic [PatW-1:0]   pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q  <= RstLineCount;
      seg_cnt_q   <= RstSegCount;
      line_len_q  <= RstLineLen;
      seg_len_q   <= RstSegLen;
      flags_q     <= RstFlags;
      loop_freq_q <= RstLoopFreq;
      bg_freq_q   <= RstBgFreq;
      pat_len_q   <= RstPatLen;
    end else if (cfg_we_i) begin
      case (lcws_reg_e'(cfg_index_i))
        REG_LINE_COUNT:  line_cnt_q  <= cfg_data_i[CountW-1:0];
        REG_SEG_COUNT:   seg_cnt_q   <= cfg_data_i[CountW-1:0];
        REG_LINE_LEN:    line_len_q  <= cfg_data_i[CountW-1:0];
        REG_SEG_LEN:     seg_len_q   <= cfg_data_i[CountW-1:0];
        REG_MODE_FLAGS:  flags_q     <= cfg_data_i[FlagW-1:0];
        REG_LOOP_FREQ:   loop_freq_q <= cfg_data_i[FreqW-1:0];
        REG_BG_FREQ:     bg_freq_q   <= cfg_data_i[FreqW-1:0];
        REG_PATTERN_LEN: pat_len_q   <= cfg_data_i[PatW-1:0];
        default:         flags_q     <= flags_q;
      endcase
    end
  end

  // Sequence state.
  logic [IdxW-1:0]   step_q, seq_idx_q;
  logic [CountW-1:0] seq_base_q, len_q, total_q, rem_q;
  logic              cur_dir_q, start_dir_q, seg_dir_q, segm_q, bg_q, all_done_q;
  logic [ShiftW-1:0] shift_q;
  logic [LoopW-1:0]  loop_q;
  logic [FreqW-1:0]  rl_q, rb_q;
  // Element iterator.
  logic [IdxW-1:0]   i_q;
  logic [CountW-1:0] base_q;
  logic              dir_q;

  logic simult, alt;
  assign simult = flags_q[FlagSimult];
  assign alt    = flags_q[FlagAlternate];

  // Element count and wipe length of the current mode.
  logic [CountW-1:0] cnt_raw, count, len_raw, len_new, lim;
  assign cnt_raw = segm_q ? seg_cnt_q : line_cnt_q;
  assign count   = (cnt_raw == '0) ? CountW'(1) :
                   (cnt_raw > CountW'(MAX_LINES)) ? CountW'(MAX_LINES) : cnt_raw;
  assign len_raw = segm_q ? seg_len_q : line_len_q;
  assign len_new = (len_raw == '0 || len_raw > count) ? count : len_raw;
  assign lim     = count - CountW'(1);

  // Current element.
  logic [NumW-1:0] num_f, num_b, num, lim8, num_eff, step_eff8;
  logic [NumW-1:0] base2, num_f2, num_b2, num2;
  logic            clip, clip2, dir2, last_e, fin_e, fin_r;
  logic [CountW-1:0] step_eff;

  assign lim8   = NumW'(lim);
  assign num_f  = NumW'(base_q) + NumW'(step_q);
  assign num_b  = NumW'(base_q) + NumW'(len_q) - NumW'(1) - NumW'(step_q);
  assign num    = dir_q ? num_f : num_b;
  assign clip   = num > lim8;
  assign num_eff = (clip && !simult) ? lim8 : num;
  assign step_eff8 = (clip && !simult) ?
                     (dir_q ? (NumW'(len_q) - NumW'(1)) : (num - lim8)) : NumW'(step_q);
  assign step_eff = step_eff8[CountW-1:0];

  // Next element of a simultaneous tick, to tell whether it is clipped.
  assign dir2   = dir_q ^ alt;
  assign base2  = NumW'(base_q) + NumW'(len_q);
  assign num_f2 = base2 + NumW'(step_q);
  assign num_b2 = base2 + NumW'(len_q) - NumW'(1) - NumW'(step_q);
  assign num2   = dir2 ? num_f2 : num_b2;
  assign clip2  = num2 > lim8;

  assign last_e = !simult || (CountW'(i_q) + CountW'(1) == total_q) ||
                  ((CountW'(i_q) + CountW'(2) == total_q) && clip2);

  assign fin_e = (step_eff + CountW'(1) >= len_q) &&
                 (simult || (CountW'(seq_idx_q) + CountW'(1) >= total_q));
  assign fin_r = (CountW'(step_q) + CountW'(1) >= len_q) &&
                 (simult || (CountW'(seq_idx_q) + CountW'(1) >= total_q));

  logic [NumW-1:0] tgt;
  assign tgt = seg_dir_q ? num_eff : (lim8 - num_eff);

  // Loop bookkeeping. rl tracks loop % loop_freq and rb (loop + 1) % bg_freq.
  logic [FreqW-1:0]  lf_eff, bf_eff, rl_n, rb_n;
  logic [LoopW-1:0]  loop_n;
  logic [PatW-1:0]   plen;
  logic [ShiftW-1:0] shift_inc;
  logic              bg_n, sd_n;

  assign lf_eff = (loop_freq_q == '0) ? FreqW'(1) : loop_freq_q;
  assign bf_eff = (bg_freq_q < FreqW'(2)) ? FreqW'(2) : bg_freq_q;
  assign loop_n = loop_q + LoopW'(1);
  assign rl_n   = (loop_n == '0) ? '0 :
                  ((rl_q + FreqW'(1) == lf_eff) ? '0 : rl_q + FreqW'(1));
  assign rb_n   = (loop_n == '1) ? '0 :
                  ((rb_q + FreqW'(1) == bf_eff) ? '0 : rb_q + FreqW'(1));
  assign bg_n   = flags_q[FlagBgLoop] && (rb_n == '0);
  assign plen   = (pat_len_q == '0) ? PatW'(1) :
                  ((32'(pat_len_q) > MAX_PATTERN) ? PatW'(MAX_PATTERN) : pat_len_q);
  assign shift_inc = (shift_q + ShiftW'(1) >= plen) ? '0 : shift_q + ShiftW'(1);
  assign sd_n   = start_dir_q ^ (flags_q[FlagAltWipe] &&
                                 (!flags_q[FlagBgAlt] || !bg_n));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      seq_idx_q   <= '0;
      seq_base_q  <= '0;
      len_q       <= CountW'(1);
      total_q     <= CountW'(1);
      rem_q       <= '0;
      cur_dir_q   <= 1'b0;
      start_dir_q <= 1'b0;
      seg_dir_q   <= 1'b0;
      segm_q      <= 1'b0;
      bg_q        <= 1'b0;
      all_done_q  <= 1'b0;
      shift_q     <= '0;
      loop_q      <= '0;
      rl_q        <= '0;
      rb_q        <= FreqW'(1);
      i_q         <= '0;
      base_q      <= '0;
      dir_q       <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        start_dir_q <= flags_q[FlagForward];
        cur_dir_q   <= flags_q[FlagForward];
        seg_dir_q   <= flags_q[FlagSegForward];
        segm_q      <= flags_q[FlagSegMode];
        step_q      <= '0;
        seq_idx_q   <= '0;
        seq_base_q  <= '0;
        bg_q        <= 1'b0;
        shift_q     <= '0;
        loop_q      <= '0;
        rl_q        <= '0;
        rb_q        <= FreqW'(1);
        all_done_q  <= 1'b0;
      end
      if (cmd_i.div_load) begin
        len_q   <= len_new;
        rem_q   <= count;
        total_q <= '0;
      end
      if (cmd_i.div_step) begin
        total_q <= total_q + CountW'(1);
        if (rem_q > len_q) rem_q <= rem_q - len_q;
      end
      if (cmd_i.start) begin
        i_q    <= simult ? '0 : seq_idx_q;
        base_q <= simult ? '0 : seq_base_q;
        dir_q  <= simult ? start_dir_q : cur_dir_q;
        if (simult) cur_dir_q <= start_dir_q;
      end
      if (cmd_i.emit) begin
        if (!simult) step_q <= step_eff[IdxW-1:0];
        i_q    <= i_q + IdxW'(1);
        base_q <= base_q + len_q;
        dir_q  <= dir_q ^ (simult && alt);
      end
      if (cmd_i.end_tick) begin
        if (CountW'(step_q) + CountW'(1) < len_q) begin
          step_q <= step_q + IdxW'(1);
        end else if (fin_r) begin
          if (flags_q[FlagLooped]) begin
            all_done_q <= 1'b0;
            seq_idx_q  <= '0;
            seq_base_q <= '0;
            step_q     <= '0;
            loop_q     <= loop_n;
            rl_q       <= rl_n;
            rb_q       <= rb_n;
            bg_q       <= bg_n;
            if (flags_q[FlagAltSegMode]) segm_q <= !segm_q;
            if (rl_n == '0) begin
              if (flags_q[FlagAltSegDir]) seg_dir_q <= !seg_dir_q;
              start_dir_q <= sd_n;
              cur_dir_q   <= sd_n;
              if (flags_q[FlagShiftPat] && !bg_n) shift_q <= shift_inc;
            end
          end else begin
            all_done_q <= 1'b1;
          end
        end else begin
          seq_idx_q  <= seq_idx_q + IdxW'(1);
          seq_base_q <= seq_base_q + len_q;
          step_q     <= '0;
          if (alt) cur_dir_q <= !cur_dir_q;
        end
      end
    end
  end

  // Output register.
  logic            out_valid_q;
  logic [IdxW-1:0] o_tgt_q, o_num_q, o_step_q;
  logic [OffW-1:0] o_off_q;
  logic            o_seg_q, o_bg_q, o_fin_q, o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_tgt_q  <= tgt[IdxW-1:0];
      o_seg_q  <= segm_q;
      o_num_q  <= i_q;
      o_step_q <= step_eff[IdxW-1:0];
      o_off_q  <= shift_q[OffW-1:0];
      o_bg_q   <= bg_q;
      o_fin_q  <= fin_e;
      o_last_q <= last_e;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.target_index      = o_tgt_q;
  assign out_o.target_is_segment = o_seg_q;
  assign out_o.wipe_number       = o_num_q;
  assign out_o.wipe_step         = o_step_q;
  assign out_o.pattern_offset    = o_off_q;
  assign out_o.background        = o_bg_q;
  assign out_o.sequence_finished = o_fin_q;
  assign out_o.last              = o_last_q;

  assign st_o.div_done = rem_q <= len_q;
  assign st_o.all_done = all_done_q;
  assign st_o.out_free = !out_valid_q || out_o.ready;
  assign st_o.last     = last_e;
  assign st_o.reload   = fin_r && flags_q[FlagLooped] && flags_q[FlagAltSegMode] &&
                         !(CountW'(step_q) + CountW'(1) < len_q);

  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> (CountW'(step_q) < len_q) && (total_q != '0))
    else $error("tick started with inconsistent wipe state");

endmodule

`default_nettype wire
